/* src/mff_pkg.sv */
// Shared types and constants of the message fragmenter and framer.
package mff_pkg;

   // One request: a payload byte with its message attributes
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [7:0]  slot;
      logic [7:0]  msg_type;
      logic [15:0] message_length;
   } req_type;

   // One result: a byte of the framed stream
   typedef struct packed {
      logic [7:0] out_byte;
      logic       fragment_end;
      logic       last_of_run;
   } rsp_type;

   // Classified byte handed from the front to the back
   typedef struct packed {
      logic        hdr;       // fragment starts here: emit header first
      logic [15:0] flen;      // header length field
      logic [7:0]  slot;
      logic [7:0]  msg_type;
      logic [7:0]  seq;
      logic        more;
      logic [7:0]  data_byte;
      logic        fend;
   } cmd_type;

   // Header constants
   localparam logic [7:0]  SYNC0      = 8'hAB;
   localparam logic [7:0]  SYNC1      = 8'hCD;
   localparam logic [15:0] HDR_LEN    = 16'd8;

   // Back-end step codes: header byte positions, then the payload byte
   localparam int unsigned STEP_W     = 4;
   localparam logic [STEP_W-1:0] STEP_SYNC0 = 4'd0;
   localparam logic [STEP_W-1:0] STEP_SYNC1 = 4'd1;
   localparam logic [STEP_W-1:0] STEP_LENLO = 4'd2;
   localparam logic [STEP_W-1:0] STEP_LENHI = 4'd3;
   localparam logic [STEP_W-1:0] STEP_SLOT  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_TYPE  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_SEQ   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_MORE  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_DATA  = 4'd8;

endpackage

/* src/mff_front.sv */
// Front end: accepts requests, tracks message position and classifies each byte.
module mff_front #(
   parameter int unsigned FRAG_BYTES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  mff_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output mff_pkg::cmd_type q_data
);

   localparam int unsigned PW = (FRAG_BYTES > 1) ? $clog2(FRAG_BYTES) : 1;

   logic [15:0]   off_ff, off_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    seq_ff, seq_in;
   logic [15:0]   len_ff, len_in;
   logic [7:0]    slot_ff, slot_in;
   logic [7:0]    type_ff, type_in;

   logic        first, drop, accept, last_byte, pos_last, fend;
   logic [15:0] eff_len, remaining, cur, psize;
   logic [7:0]  eff_slot, eff_type, eff_seq;

   // Classify the incoming byte
   always_comb begin
      psize     = 16'(FRAG_BYTES);
      first     = (off_ff == 16'd0);
      eff_len   = first ? req_data.message_length : len_ff;
      eff_slot  = first ? req_data.slot : slot_ff;
      eff_type  = first ? req_data.msg_type : type_ff;
      eff_seq   = first ? 8'd0 : seq_ff;
      drop      = first && (req_data.message_length == 16'd0);
      accept    = req_valid && !q_full;
      remaining = eff_len - off_ff;
      cur       = (remaining < psize) ? remaining : psize;
      last_byte = ((off_ff + 16'd1) == eff_len);
      pos_last  = (pos_ff == PW'(FRAG_BYTES - 1));
      fend      = pos_last || last_byte;

      q_push           = accept && !drop;
      q_data.hdr       = (pos_ff == '0);
      q_data.flen      = mff_pkg::HDR_LEN + cur;
      q_data.slot      = eff_slot;
      q_data.msg_type  = eff_type;
      q_data.seq       = eff_seq;
      q_data.more      = (remaining > psize);
      q_data.data_byte = req_data.data_byte;
      q_data.fend      = fend;
   end

   // Advance the message position on each kept byte
   always_comb begin
      off_in  = off_ff;
      pos_in  = pos_ff;
      seq_in  = seq_ff;
      len_in  = len_ff;
      slot_in = slot_ff;
      type_in = type_ff;
      if (q_push) begin
         len_in  = eff_len;
         slot_in = eff_slot;
         type_in = eff_type;
         if (last_byte) begin
            off_in = 16'd0;
            pos_in = '0;
            seq_in = 8'd0;
         end else begin
            off_in = off_ff + 16'd1;
            pos_in = pos_last ? '0 : pos_ff + PW'(1);
            seq_in = fend ? eff_seq + 8'd1 : eff_seq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff  <= 16'd0;
         pos_ff  <= '0;
         seq_ff  <= 8'd0;
         len_ff  <= 16'd0;
         slot_ff <= 8'd0;
         type_ff <= 8'd0;
      end else begin
         off_ff  <= off_in;
         pos_ff  <= pos_in;
         seq_ff  <= seq_in;
         len_ff  <= len_in;
         slot_ff <= slot_in;
         type_ff <= type_in;
      end
   end

endmodule

/* src/mff_queue.sv */
// Short register queue of classified bytes between front and back.
module mff_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mff_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output mff_pkg::cmd_type head
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   mff_pkg::cmd_type slots_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = slots_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers and count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* src/mff_back.sv */
// Back end: expands each classified byte into header and payload bytes.
module mff_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  mff_pkg::cmd_type q_head,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output mff_pkg::rsp_type rsp_data
);

   logic [mff_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       valid_ff, valid_in;
   mff_pkg::rsp_type           out_ff, out_in;
   logic                       slot_free, emit;
   logic [mff_pkg::STEP_W-1:0] cur_step;
   logic [7:0]                 hbyte;

   assign slot_free = !valid_ff || rsp_pop;
   assign emit      = slot_free && !q_empty;
   assign cur_step  = q_head.hdr ? step_ff : mff_pkg::STEP_DATA;
   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

   // Select the byte for the current step
   always_comb begin
      unique case (cur_step)
         mff_pkg::STEP_SYNC0: hbyte = mff_pkg::SYNC0;
         mff_pkg::STEP_SYNC1: hbyte = mff_pkg::SYNC1;
         mff_pkg::STEP_LENLO: hbyte = q_head.flen[7:0];
         mff_pkg::STEP_LENHI: hbyte = q_head.flen[15:8];
         mff_pkg::STEP_SLOT:  hbyte = q_head.slot;
         mff_pkg::STEP_TYPE:  hbyte = q_head.msg_type;
         mff_pkg::STEP_SEQ:   hbyte = q_head.seq;
         mff_pkg::STEP_MORE:  hbyte = {7'd0, q_head.more};
         default:             hbyte = q_head.data_byte;
      endcase
   end

   // Step through the entry and load the output register
   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      q_pop    = 1'b0;
      if (slot_free) begin
         valid_in = emit;
      end
      if (emit) begin
         out_in.out_byte = hbyte;
         if (cur_step == mff_pkg::STEP_DATA) begin
            out_in.fragment_end = q_head.fend;
            out_in.last_of_run  = 1'b1;
            step_in             = mff_pkg::STEP_SYNC0;
            q_pop               = 1'b1;
         end else begin
            out_in.fragment_end = 1'b0;
            out_in.last_of_run  = 1'b0;
            step_in             = step_ff + mff_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= mff_pkg::STEP_SYNC0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

/* src/message_fragmenter_framer_top.sv */
// Top level of the message fragmenter and framer.
//
//   channel   ports                        direction  transfer when
//   request   push, full, req_data         in         push && !full
//   response  pop, empty, rsp_data         out        pop && !empty
//
// A request that opens a fragment yields 9 response bytes (8 header bytes, then the
// payload byte); any other request yields 1 byte. The back end emits one byte per
// cycle, the sustained rate, when the queue has an entry and the output is not stalled.
// Requests are taken while the classified-byte queue (QUEUE_DEPTH entries) has room.
// A zero-length first byte is accepted and dropped with no response.
// Synchronous active-high reset clears position, queue and output valid.
module message_fragmenter_framer_top #(
   parameter int unsigned FRAG_BYTES  = 64,
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  mff_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output mff_pkg::rsp_type rsp_data
);

   logic             q_push, q_full, q_pop, q_empty;
   mff_pkg::cmd_type q_in, q_head;

   assign full = q_full;

   mff_front #(
      .FRAG_BYTES(FRAG_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   mff_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   mff_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_empty(empty),
      .rsp_pop  (pop),
      .rsp_data (rsp_data)
   );

endmodule

/* dv/tb.sv */
// Self-checking testbench for the message fragmenter and framer.
module tb;

   localparam int unsigned FRAG_BYTES = 64;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             push = 1'b0;
   logic             pop = 1'b0;
   logic             full;
   logic             empty;
   mff_pkg::req_type req_data = '0;
   mff_pkg::rsp_type rsp_data;

   // Framer state mirrored by the predictor
   logic [15:0] msg_offset = '0;
   logic [7:0]  frag_seq = '0;
   logic [15:0] held_length = '0;
   logic [7:0]  held_slot = '0;
   logic [7:0]  held_type = '0;

   mff_pkg::rsp_type framed_bytes[$];
   int unsigned      error_count = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_stall_pct = 0;

   always #1 clock = ~clock;

   message_fragmenter_framer_top #(
      .FRAG_BYTES(FRAG_BYTES)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_data(req_data),
      .empty   (empty),
      .pop     (pop),
      .rsp_data(rsp_data)
   );

   function automatic void expect_byte(input logic [7:0] value, input logic fend,
                                       input logic last);
      mff_pkg::rsp_type b;
      b.out_byte = value;
      b.fragment_end = fend;
      b.last_of_run = last;
      framed_bytes.insert(framed_bytes.size(), b);
   endfunction

   // Work out the framed bytes caused by one accepted request
   function automatic void frame_request(input mff_pkg::req_type r);
      int unsigned pos;
      int unsigned remaining;
      int unsigned cur;
      int unsigned next_offset;
      logic [15:0] flen;
      logic        fend;
      if (msg_offset == 0) begin
         // drop a zero-length first byte
         if (r.message_length == 0) return;
         held_length = r.message_length;
         held_slot = r.slot;
         held_type = r.msg_type;
         frag_seq = '0;
      end
      pos = msg_offset % FRAG_BYTES;
      if (pos == 0) begin
         remaining = held_length - msg_offset;
         cur = (remaining < FRAG_BYTES) ? remaining : FRAG_BYTES;
         flen = 16'(mff_pkg::HDR_LEN + cur);
         expect_byte(mff_pkg::SYNC0, 1'b0, 1'b0);
         expect_byte(mff_pkg::SYNC1, 1'b0, 1'b0);
         expect_byte(flen[7:0], 1'b0, 1'b0);
         expect_byte(flen[15:8], 1'b0, 1'b0);
         expect_byte(held_slot, 1'b0, 1'b0);
         expect_byte(held_type, 1'b0, 1'b0);
         expect_byte(frag_seq, 1'b0, 1'b0);
         expect_byte({7'd0, remaining > FRAG_BYTES}, 1'b0, 1'b0);
      end
      next_offset = msg_offset + 1;
      fend = (pos + 1 == FRAG_BYTES) || (next_offset >= held_length);
      expect_byte(r.data_byte, fend, 1'b1);
      // advance position; rewind at end of message
      if (next_offset >= held_length) begin
         msg_offset = '0;
         frag_seq = '0;
      end else begin
         msg_offset = 16'(next_offset);
         if (fend) frag_seq = frag_seq + 8'd1;
      end
   endfunction

   // Send one request; returns at the edge where it is accepted
   task automatic send_request(input mff_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      frame_request(r);
   endtask

   task automatic send_fields(input logic [7:0] data, input logic [7:0] slot,
                              input logic [7:0] mtype, input logic [15:0] len);
      mff_pkg::req_type r;
      r.data_byte = data;
      r.slot = slot;
      r.msg_type = mtype;
      r.message_length = len;
      send_request(r);
   endtask

   // Hold the sender until every framed byte has arrived
   task automatic wait_drained();
      push <= 1'b0;
      while (framed_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Check each accepted response byte and drive pop
   always @(posedge clock) begin
      mff_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         if (framed_bytes.size() == 0) begin
            $error("response byte %0h with no request pending", rsp_data.out_byte);
            error_count++;
         end else begin
            want = framed_bytes.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_data.out_byte);
               error_count++;
            end
            if (rsp_data.fragment_end !== want.fragment_end) begin
               $error("fragment_end: expected %0b, got %0b", want.fragment_end,
                      rsp_data.fragment_end);
               error_count++;
            end
            if (rsp_data.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                      rsp_data.last_of_run);
               error_count++;
            end
         end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Single-byte messages at the field extremes
   task automatic test_single_byte();
      send_fields(8'h00, 8'h00, 8'h00, 16'd1);
      send_fields(8'hFF, 8'hFF, 8'hFF, 16'd1);
      send_fields(8'h5A, 8'h00, 8'hFF, 16'd1);
      send_fields(8'hA5, 8'hFF, 8'h00, 16'd1);
      wait_drained();
   endtask

   // Zero-length first bytes drop, state kept; mid-message length is ignored
   task automatic test_zero_length();
      send_fields(8'hFF, 8'hFF, 8'hFF, 16'd0);
      send_fields(8'h00, 8'h12, 8'h34, 16'd0);
      send_fields(8'h77, 8'h56, 8'h78, 16'd2);
      send_fields(8'h88, 8'hFF, 8'hFF, 16'd0);
      wait_drained();
   endtask

   // One byte past a full fragment: more flag, second header, ignored fields
   task automatic test_fragment_split();
      send_fields(8'($urandom), 8'h3C, 8'hC3, 16'(FRAG_BYTES + 1));
      for (int i = 1; i <= FRAG_BYTES; i++)
         send_fields(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
      wait_drained();
   endtask

   // Random message stream with short, boundary and medium lengths
   task automatic send_random_items(input int unsigned count);
      logic [15:0] len;
      int unsigned pick;
      for (int i = 0; i < count; i++) begin
         len = 16'($urandom);
         if (msg_offset == 0) begin
            pick = $urandom_range(9);
            unique case (pick)
               0:       len = 16'd0;
               1, 2, 3: len = 16'($urandom_range(1, 8));
               4, 5:    len = 16'($urandom_range(FRAG_BYTES - 1, FRAG_BYTES + 1));
               6:       len = 16'(2 * FRAG_BYTES);
               7:       len = 16'($urandom_range(FRAG_BYTES + 2, 2 * FRAG_BYTES + 3));
               default: len = 16'($urandom_range(1, 3));
            endcase
         end
         send_fields(8'($urandom), 8'($urandom), 8'($urandom), len);
      end
   endtask

   task automatic test_random_traffic();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_random_items(25);
      wait_drained();
      send_idle_pct = 57;
      send_random_items(25);
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 57;
      send_random_items(25);
      wait_drained();
      send_idle_pct = 30;
      recv_stall_pct = 30;
      send_random_items(25);
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_byte();
      test_zero_length();
      test_fragment_split();
      test_random_traffic();
      repeat (50) @(posedge clock);
      if (error_count == 0 && framed_bytes.size() == 0) begin
         $display("message_fragmenter_framer_top regression: pass");
      end else begin
         $display("message_fragmenter_framer_top regression: fail");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("message_fragmenter_framer_top regression: fail");
      $finish;
   end

endmodule
